// ----- hw/rtl/lprd_pkg.sv -----
// ----------------------------------------------------------------------------
// lprd_pkg
// Shared widths, constants, codes and bundle types of the pulse rate detector.
// ----------------------------------------------------------------------------
package lprd_pkg;

  localparam int NUM_SIDES   = 4;
  localparam int SIDE_W      = 2;
  localparam int TIME_W      = 32;
  localparam int PERIOD_W    = 19;
  localparam int COUNT_W     = 8;
  localparam int MS_W        = 9;
  localparam int HOLD_W      = 16;
  localparam int CODE_W      = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 24;

  localparam logic [TIME_W-1:0]  PERIOD_LIMIT_US = 32'd500000;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = '1;

  // floor(x / 1000) == (x * RECIP_MUL) >> RECIP_SHIFT for every x below 2^22
  localparam int                 RECIP_W     = 20;
  localparam logic [RECIP_W-1:0] RECIP_MUL   = 20'd536871;
  localparam int                 RECIP_SHIFT = 29;
  localparam int                 PROD_W      = PERIOD_W + RECIP_W;

  localparam logic [MS_W-1:0]    PRF_MIN_RST    = 9'd2;
  localparam logic [MS_W-1:0]    PRF_MAX_RST    = 9'd20;
  localparam logic [COUNT_W-1:0] MIN_PULSES_RST = 8'd3;
  localparam logic [HOLD_W-1:0]  HOLD_MS_RST    = 16'd3000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRF_MIN    = 2'd0,
    CFG_PRF_MAX    = 2'd1,
    CFG_MIN_PULSES = 2'd2,
    CFG_HOLD_MS    = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_SETTLE
  } state_t;

  // token that walks the cell chain during a poll
  typedef struct packed {
    logic                active;
    logic                hit;
    logic [CODE_W-1:0]   code;
    logic [MS_W-1:0]     ms;
    logic [COUNT_W-1:0]  count;
  } scan_t;

  // pulse write broadcast to every cell
  typedef struct packed {
    logic                valid;
    logic [CODE_W-1:0]   code;
    logic [TIME_W-1:0]   time_us;
  } pulse_t;

  typedef struct packed {
    logic [MS_W-1:0]     prf_min;
    logic [MS_W-1:0]     prf_max;
    logic [COUNT_W-1:0]  min_pulses;
  } thresh_t;

endpackage

// ----- hw/rtl/lprd_cell.sv -----
// ----------------------------------------------------------------------------
// lprd_cell
// State of one side: last pulse time, period, count, fresh mark; one scan hop.
// ----------------------------------------------------------------------------
module lprd_cell import lprd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [CODE_W-1:0] cell_code,
  input  pulse_t            pulse,
  input  logic              clear,
  input  thresh_t           thresh,
  input  scan_t             scan_in,
  output scan_t             scan_out
);

  logic [TIME_W-1:0]   last_time;
  logic [PERIOD_W-1:0] period;
  logic [COUNT_W-1:0]  count;
  logic                fresh;
  logic [MS_W-1:0]     ms;

  logic [TIME_W-1:0]   delta;
  logic [PROD_W-1:0]   prod;
  logic                hit_pulse;
  logic                take;
  logic                match;
  scan_t               scan_next;

  assign hit_pulse = pulse.valid && (pulse.code == cell_code);
  assign delta     = pulse.time_us - last_time;
  assign prod      = PROD_W'(period) * PROD_W'(RECIP_MUL);

  // examine this side only if the token is still looking and the side has news
  assign take  = scan_in.active && !scan_in.hit && fresh;
  assign match = take && (ms >= thresh.prf_min) && (ms <= thresh.prf_max) &&
                 (count >= thresh.min_pulses);

  always_comb begin
    scan_next = scan_in;
    if (match) begin
      scan_next.hit   = 1'b1;
      scan_next.code  = cell_code;
      scan_next.ms    = ms;
      scan_next.count = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time <= '0;
      period    <= '0;
      count     <= '0;
      fresh     <= 1'b0;
      ms        <= '0;
      scan_out  <= '0;
    end else begin
      ms       <= prod[RECIP_SHIFT +: MS_W];
      scan_out <= scan_next;
      if (hit_pulse) begin
        last_time <= pulse.time_us;
        if ((delta != '0) && (delta < PERIOD_LIMIT_US)) begin
          period <= delta[PERIOD_W-1:0];
        end
        if (count != COUNT_MAX) begin
          count <= count + 1'b1;
        end
        fresh <= 1'b1;
      end
      if (take) begin
        fresh <= 1'b0;
      end
      if (clear) begin
        period <= '0;
        count  <= '0;
      end
    end
  end

endmodule

// ----- hw/rtl/lprd_ctrl.sv -----
// ----------------------------------------------------------------------------
// lprd_ctrl
// Sequencer, alert hold timer and output register of the pulse rate detector.
// ----------------------------------------------------------------------------
module lprd_ctrl import lprd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic                   req_poll,
  input  logic [TIME_W-1:0]      poll_time,
  input  logic [HOLD_W-1:0]      hold_ms,
  output scan_t                  scan_head,
  input  scan_t                  scan_tail,
  output logic                   clear,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  state_t              state, state_next;
  logic [TIME_W-1:0]   poll_ms;
  scan_t               res;
  logic                hold_active;
  logic [TIME_W-1:0]   hold_start;
  logic [CODE_W-1:0]   held_code;

  logic                accept;
  logic                out_free;
  logic                emit;
  logic [TIME_W-1:0]   start_eff;
  logic [TIME_W-1:0]   elapsed;
  logic                expire;
  logic                alert_o;
  logic [CODE_W-1:0]   code_o;
  logic [MS_W-1:0]     ms_o;
  logic [COUNT_W-1:0]  count_o;

  assign out_free  = !m_tvalid || m_tready;
  assign start_eff = res.hit ? poll_ms : hold_start;
  assign elapsed   = poll_ms - start_eff;
  assign expire    = (res.hit || hold_active) && (elapsed >= TIME_W'(hold_ms));
  assign clear     = emit && expire;

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    accept     = 1'b0;
    emit       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        accept   = s_tvalid;
        if (s_tvalid) begin
          state_next = req_poll ? ST_SCAN : ST_SETTLE;
        end
      end
      ST_SCAN: begin
        if (scan_tail.active) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        emit = out_free;
        if (out_free) begin
          state_next = ST_SETTLE;
        end
      end
      ST_SETTLE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    alert_o = 1'b0;
    code_o  = '0;
    ms_o    = '0;
    count_o = '0;
    if (res.hit) begin
      alert_o = 1'b1;
      code_o  = res.code;
      ms_o    = res.ms;
      count_o = res.count;
    end else if (hold_active && !expire) begin
      alert_o = 1'b1;
      code_o  = held_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_head   <= '0;
      res         <= '0;
      hold_active <= 1'b0;
      hold_start  <= '0;
      held_code   <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      scan_head <= '0;
      if (accept && req_poll) begin
        scan_head.active <= 1'b1;
        poll_ms          <= poll_time;
      end
      if ((state == ST_SCAN) && scan_tail.active) begin
        res <= scan_tail;
      end
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (emit) begin
        m_tvalid    <= 1'b1;
        m_tdata     <= {{(OUT_TDATA_W - 1 - CODE_W - MS_W - COUNT_W){1'b0}},
                        count_o, ms_o, code_o, alert_o};
        hold_active <= (res.hit || hold_active) && !expire;
        if (res.hit) begin
          hold_start <= poll_ms;
          held_code  <= res.code;
        end
        if (expire) begin
          held_code <= '0;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/laser_pulse_rate_detector_core.sv -----
// ----------------------------------------------------------------------------
// laser_pulse_rate_detector_core
// Four-side laser pulse repetition interval detector with alert hold.
// ----------------------------------------------------------------------------
// Each input transaction is either a pulse (tuser low) time-stamped in
// microseconds on one side, or a poll (tuser high) time-stamped in
// milliseconds. A pulse updates that side's cell and yields no output; the
// block then passes through ST_SETTLE before it is ready again. A poll sends
// a token down the chain of side cells, one cell per clock in priority order
// front, rear, left, right; the first side with new data whose interval lies
// in [prf_min_ms, prf_max_ms] and whose pulse count reaches min_pulses wins.
// Every poll yields exactly one output transaction; no new transaction is
// taken until the token has left the chain and m_tready frees the output. An
// alert is held for hold_ms after its trigger; when the hold runs out, counts
// and intervals of all sides are cleared. Write registers through cfg_we,
// cfg_index, cfg_data only while no transaction is in flight.
// ----------------------------------------------------------------------------
module laser_pulse_rate_detector_core import lprd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // slave side
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,  // side[1:0], time_us[33:2], time_ms[65:34]
  input  logic                   s_tuser,  // req_type[0]
  // master side
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,  // alert[0], alert_side[3:1],
                                           // interval_ms[12:4], pulse_count[20:13]
  // configuration
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [MS_W-1:0]    prf_min_ms;
  logic [MS_W-1:0]    prf_max_ms;
  logic [COUNT_W-1:0] min_pulses;
  logic [HOLD_W-1:0]  hold_ms;

  logic [SIDE_W-1:0]  side;
  logic [TIME_W-1:0]  time_us;
  logic [TIME_W-1:0]  time_ms;

  thresh_t            thresh;
  pulse_t             pulse;
  logic               clear;
  scan_t              scan_link [NUM_SIDES+1];

  // unpack the slave payload
  assign side    = s_tdata[SIDE_W-1:0];
  assign time_us = s_tdata[SIDE_W +: TIME_W];
  assign time_ms = s_tdata[SIDE_W + TIME_W +: TIME_W];

  // register file, written straight from the port
  always_ff @(posedge clk) begin
    if (rst) begin
      prf_min_ms <= PRF_MIN_RST;
      prf_max_ms <= PRF_MAX_RST;
      min_pulses <= MIN_PULSES_RST;
      hold_ms    <= HOLD_MS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PRF_MIN:    prf_min_ms <= cfg_data[MS_W-1:0];
        CFG_PRF_MAX:    prf_max_ms <= cfg_data[MS_W-1:0];
        CFG_MIN_PULSES: min_pulses <= cfg_data[COUNT_W-1:0];
        CFG_HOLD_MS:    hold_ms    <= cfg_data[HOLD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign thresh.prf_min    = prf_min_ms;
  assign thresh.prf_max    = prf_max_ms;
  assign thresh.min_pulses = min_pulses;

  // broadcast an accepted pulse; each cell matches on its own side code
  assign pulse.valid   = s_tvalid && s_tready && !s_tuser;
  assign pulse.code    = CODE_W'(side) + CODE_W'(1);
  assign pulse.time_us = time_us;

  lprd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .req_poll  (s_tuser),
    .poll_time (time_ms),
    .hold_ms   (hold_ms),
    .scan_head (scan_link[0]),
    .scan_tail (scan_link[NUM_SIDES]),
    .clear     (clear),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // side cells in priority order; the token hops one cell per clock
  for (genvar i = 0; i < NUM_SIDES; i++) begin : g_cell
    lprd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cell_code (CODE_W'(i + 1)),
      .pulse     (pulse),
      .clear     (clear),
      .thresh    (thresh),
      .scan_in   (scan_link[i]),
      .scan_out  (scan_link[i+1])
    );
  end

endmodule

// ----- hw/rtl/lprd_checker.sv -----
// ----------------------------------------------------------------------------
// lprd_checker
// Port-level checks of the pulse rate detector, bound to the top level.
// ----------------------------------------------------------------------------
module lprd_checker import lprd_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   s_tuser,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // no alert means every other field is zero
  a_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> (m_tdata[20:1] == '0))
    else $error("fields set without alert");

  // alert always names a side within range
  a_side: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> (m_tdata[3:1] != 3'd0) && (m_tdata[3:1] <= 3'd4))
    else $error("alert without a valid side");

  // a pulse alone never produces a result from an empty output
  a_pulse_silent: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid && s_tvalid && s_tready && !s_tuser |=> !m_tvalid)
    else $error("pulse produced a result");

endmodule

bind laser_pulse_rate_detector_core lprd_checker u_lprd_checker (.*);
